// ===== src/debounced_bottleneck_monitor_core_assert.svh =====
// Assertion macros used by the checker file.
`ifndef DEBOUNCED_BOTTLENECK_MONITOR_CORE_ASSERT_SVH
`define DEBOUNCED_BOTTLENECK_MONITOR_CORE_ASSERT_SVH

// Same-cycle implication, disabled while reset is low.
`define DBM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define DBM_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/dbm_pkg.sv =====
package dbm_pkg;

    // Field widths
    localparam int TIME_W     = 32;
    localparam int HEALTH_W   = 15;
    localparam int WEIGHT_W   = 11;
    localparam int CNT_W      = 16;
    localparam int RUN_W      = 8;
    localparam int INTV_W     = 16;
    localparam int OFFS_W     = RUN_W + INTV_W;
    localparam int STAMP_W    = TIME_W + 1;
    localparam int NUM_FIELDS = 3;

    // Weighted sum arithmetic
    localparam int PROD_W     = WEIGHT_W + HEALTH_W;
    localparam int SUM_W      = PROD_W + 2;
    localparam int FRAC_BITS  = 10;
    localparam logic [SUM_W-1:0]    ROUND_HALF = SUM_W'(512);
    localparam logic [HEALTH_W-1:0] HEALTH_MAX = 15'd25600;
    localparam logic [RUN_W-1:0]    RUN_MAX    = '1;
    localparam logic [CNT_W-1:0]    CNT_MAX    = '1;

    // Configuration port
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_A     = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_B     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_C     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_LOW_THRESH   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_RECOVERY     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_DEBOUNCE     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_INTERVAL     = 3'd6;

    // Stream widths and result field offsets
    localparam int S_TDATA_W  = 80;
    localparam int M_TDATA_W  = 248;
    localparam int OFS_HEALTH = 0;
    localparam int OFS_ACTIVE = 15;
    localparam int OFS_MASK   = 16;
    localparam int OFS_OEV    = 19;
    localparam int OFS_EV     = 35;
    localparam int OFS_MS     = 83;
    localparam int OFS_ONSET  = 179;
    localparam int OFS_RECOV  = 212;
    localparam int OUT_USED_W = 245;

    typedef logic [HEALTH_W-1:0] health_t;
    typedef logic [TIME_W-1:0]   time_t;

    // Per-lane status seen by the merge stage
    typedef struct packed {
        logic low;      // this item's sample is below threshold
        logic active;   // debounced state as of the last item
        logic rise;     // this item makes the detector active
    } lane_stat_t;

endpackage

// ===== src/dbm_health.sv =====
module dbm_health
    import dbm_pkg::*;
(
    input  logic                                  aclk,
    input  logic                                  ld_prod,
    input  logic                                  ld_sum,
    input  logic [NUM_FIELDS-1:0][WEIGHT_W-1:0]   weight,
    input  logic [NUM_FIELDS-1:0][HEALTH_W-1:0]   health,
    output health_t                               overall
);

    logic [NUM_FIELDS-1:0][PROD_W-1:0] prod_reg;
    logic [SUM_W-1:0]                  sum;
    logic [SUM_W-FRAC_BITS-1:0]        scaled;
    health_t                           overall_reg;
    health_t                           overall_next;

    // One multiplier per channel, registered
    always_ff @(posedge aclk) begin
        if (ld_prod) begin
            for (int i = 0; i < NUM_FIELDS; i++) begin
                prod_reg[i] <= PROD_W'(weight[i]) * PROD_W'(health[i]);
            end
        end
    end

    // Sum, round half up, saturate
    always_comb begin
        sum = ROUND_HALF;
        for (int i = 0; i < NUM_FIELDS; i++) begin
            sum = sum + SUM_W'(prod_reg[i]);
        end
        scaled = sum[SUM_W-1:FRAC_BITS];
        if (scaled > (SUM_W-FRAC_BITS)'(HEALTH_MAX)) begin
            overall_next = HEALTH_MAX;
        end else begin
            overall_next = scaled[HEALTH_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_sum) begin
            overall_reg <= overall_next;
        end
    end

    assign overall = overall_reg;

endmodule

// ===== src/dbm_lane.sv =====
module dbm_lane
    import dbm_pkg::*;
#(
    parameter bit TRACK_TIME = 1'b1
)
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              step_en,
    input  health_t           health,
    input  health_t           low_threshold,
    input  logic [RUN_W-1:0]  eff_debounce,
    input  time_t             sample_time,
    input  time_t             back_time,
    output lane_stat_t        stat,
    output logic [CNT_W-1:0]  events,
    output time_t             active_ms
);

    logic [RUN_W-1:0] run_reg;
    logic [RUN_W-1:0] run_next;
    logic             prev_reg;
    logic [CNT_W-1:0] events_reg;
    logic [CNT_W-1:0] events_next;
    logic             low;
    logic             act;
    logic             rise;
    logic             fall;

    // Debounce: count consecutive low samples, saturating
    always_comb begin
        low = health < low_threshold;
        if (!low) begin
            run_next = '0;
        end else if (run_reg == RUN_MAX) begin
            run_next = RUN_MAX;
        end else begin
            run_next = run_reg + 1'b1;
        end
        act  = run_next >= eff_debounce;
        rise = act && !prev_reg;
        fall = !act && prev_reg;
        events_next = (rise && events_reg != CNT_MAX) ? events_reg + 1'b1 : events_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg    <= '0;
            prev_reg   <= 1'b0;
            events_reg <= '0;
        end else if (step_en) begin
            run_reg    <= run_next;
            prev_reg   <= act;
            events_reg <= events_next;
        end
    end

    assign stat.low    = low;
    assign stat.active = prev_reg;
    assign stat.rise   = rise;
    assign events      = events_reg;

    // Active time of closed runs
    generate
        if (TRACK_TIME) begin : g_time
            logic             start_vld_reg;
            time_t            start_reg;
            time_t            total_reg;
            time_t            diff;
            logic [TIME_W:0]  total_sum;
            time_t            total_next;

            always_comb begin
                diff       = (sample_time >= start_reg) ? sample_time - start_reg : '0;
                total_sum  = {1'b0, total_reg} + {1'b0, diff};
                total_next = total_sum[TIME_W] ? '1 : total_sum[TIME_W-1:0];
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    start_vld_reg <= 1'b0;
                    total_reg     <= '0;
                end else if (step_en) begin
                    if (rise) begin
                        start_vld_reg <= 1'b1;
                    end else if (fall && start_vld_reg) begin
                        start_vld_reg <= 1'b0;
                        total_reg     <= total_next;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (step_en && rise) begin
                    start_reg <= back_time;
                end
            end

            assign active_ms = total_reg;
        end else begin : g_no_time
            assign active_ms = '0;
        end
    endgenerate

endmodule

// ===== src/dbm_merge.sv =====
module dbm_merge
    import dbm_pkg::*;
(
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                step_en,
    input  health_t                             overall,
    input  health_t                             recovery_level,
    input  time_t                               sample_time,
    input  time_t                               back_time,
    input  lane_stat_t                          ov_stat,
    input  logic [CNT_W-1:0]                    ov_events,
    input  logic [NUM_FIELDS-1:0]               ch_mask,
    input  logic [NUM_FIELDS-1:0][CNT_W-1:0]    ch_events,
    input  logic [NUM_FIELDS-1:0][TIME_W-1:0]   ch_ms,
    output logic [M_TDATA_W-1:0]                tdata
);

    health_t            health_reg;
    logic               onset_vld_reg;
    time_t              onset_reg;
    logic               recov_vld_reg;
    time_t              recov_reg;
    logic               set_onset;
    logic               set_recov;
    logic [STAMP_W-1:0] onset_field;
    logic [STAMP_W-1:0] recov_field;

    // First overall onset and first recovery
    always_comb begin
        set_onset = ov_stat.rise && !onset_vld_reg;
        set_recov = !ov_stat.low && ov_stat.active && !recov_vld_reg
                    && (overall > recovery_level);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            onset_vld_reg <= 1'b0;
            recov_vld_reg <= 1'b0;
        end else if (step_en) begin
            if (set_onset) begin
                onset_vld_reg <= 1'b1;
            end
            if (set_recov) begin
                recov_vld_reg <= 1'b1;
            end
        end
    end

    // Output-side payload: health and stamps of the item in the output slot
    always_ff @(posedge aclk) begin
        if (step_en) begin
            health_reg <= overall;
            if (set_onset) begin
                onset_reg <= back_time;
            end
            if (set_recov) begin
                recov_reg <= sample_time;
            end
        end
    end

    // None-yet reads as all ones (-1)
    assign onset_field = onset_vld_reg ? {1'b0, onset_reg} : '1;
    assign recov_field = recov_vld_reg ? {1'b0, recov_reg} : '1;

    assign tdata = {
        {(M_TDATA_W-OUT_USED_W){1'b0}},
        recov_field,
        onset_field,
        ch_ms[2], ch_ms[1], ch_ms[0],
        ch_events[2], ch_events[1], ch_events[0],
        ov_events,
        ch_mask,
        ov_stat.active,
        health_reg
    };

endmodule

// ===== src/debounced_bottleneck_monitor_core.sv =====
// Debounced bottleneck monitor.
// Input stream (s_*): one item per sample tick, carrying the sample time and
// three channel health levels. Result stream (m_*): one item per input item,
// in order, with the weighted overall health, debounced active flags, event
// counters, closed active time per channel and the first onset and recovery
// stamps. Configuration is a write-only register port (cfg_*), written while
// no items are in flight; a debounce or interval write is registered before it
// reaches the back-dating offset register.
// Pipeline: input register, weight multipliers, sum and saturate, then the lane
// update into the output register. Throughput: one item per cycle while the
// receiver keeps m_tready high, set by the lane update stage, which touches
// each detector once per item.
// The four stages carry their own valid bits, so s_tready stays high while a
// result waits as long as an earlier stage is empty. When the receiver holds
// m_tready low, the pipe fills and s_tready drops after three more items.
// Reset clears all counters, detectors and stamps and loads the default
// register values; no item is in flight afterwards.
module debounced_bottleneck_monitor_core
    import dbm_pkg::*;
#(
    parameter int NUM_CHANNELS = 3
)
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [CFG_DATA_W-1:0]   cfg_wr_data,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // sample_time_ms[31:0], health_a[46:32], health_b[61:47], health_c[76:62], zero pad
    input  logic [S_TDATA_W-1:0]    s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // overall_health[14:0], overall_active[15], channel_active_mask[18:16],
    // overall_events[34:19], events_a/b/c[82:35], active_ms_a/b/c[178:83],
    // first_onset_ms[211:179], first_recovery_ms[244:212], zero pad
    output logic [M_TDATA_W-1:0]    m_tdata
);

    // Configuration registers
    logic [NUM_FIELDS-1:0][WEIGHT_W-1:0] weight_reg;
    health_t                             low_thr_reg;
    health_t                             recov_lvl_reg;
    logic [RUN_W-1:0]                    debounce_reg;
    logic [INTV_W-1:0]                   interval_reg;
    logic [RUN_W-1:0]                    eff_debounce;
    logic [OFFS_W-1:0]                   offset_reg;

    // Pipeline
    logic                                v1_reg, v2_reg, v3_reg, m_valid_reg;
    logic                                rdy1, rdy2, rdy3, rdy_out, step_en;
    time_t                               t1_reg, t2_reg, t3_reg;
    logic [NUM_FIELDS-1:0][HEALTH_W-1:0] h1_reg, h2_reg, h3_reg;
    health_t                             overall;
    time_t                               back_time;

    // Lanes
    lane_stat_t                          ov_stat;
    logic [CNT_W-1:0]                    ov_events;
    time_t                               ov_ms;
    lane_stat_t                          ch_stat   [NUM_CHANNELS];
    logic [CNT_W-1:0]                    ch_events [NUM_CHANNELS];
    time_t                               ch_ms     [NUM_CHANNELS];
    health_t                             ch_health [NUM_CHANNELS];
    logic [NUM_FIELDS-1:0]               rep_mask;
    logic [NUM_FIELDS-1:0][CNT_W-1:0]    rep_events;
    logic [NUM_FIELDS-1:0][TIME_W-1:0]   rep_ms;

    // Register writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            weight_reg[0] <= 11'd307;
            weight_reg[1] <= 11'd512;
            weight_reg[2] <= 11'd205;
            low_thr_reg   <= 15'd12800;
            recov_lvl_reg <= 15'd17920;
            debounce_reg  <= 8'd5;
            interval_reg  <= 16'd1000;
        end else if (cfg_wr_en) begin
            unique case (cfg_addr)
                REG_WEIGHT_A:   weight_reg[0] <= cfg_wr_data[WEIGHT_W-1:0];
                REG_WEIGHT_B:   weight_reg[1] <= cfg_wr_data[WEIGHT_W-1:0];
                REG_WEIGHT_C:   weight_reg[2] <= cfg_wr_data[WEIGHT_W-1:0];
                REG_LOW_THRESH: low_thr_reg   <= cfg_wr_data[HEALTH_W-1:0];
                REG_RECOVERY:   recov_lvl_reg <= cfg_wr_data[HEALTH_W-1:0];
                REG_DEBOUNCE:   debounce_reg  <= cfg_wr_data[RUN_W-1:0];
                REG_INTERVAL:   interval_reg  <= cfg_wr_data[INTV_W-1:0];
                default: ;
            endcase
        end
    end

    // A debounce count of zero acts as one
    assign eff_debounce = (debounce_reg == '0) ? RUN_W'(1) : debounce_reg;

    // Back-dating offset: (debounce - 1) sample intervals
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            offset_reg <= OFFS_W'(4000);
        end else begin
            offset_reg <= OFFS_W'(eff_debounce - 1'b1) * OFFS_W'(interval_reg);
        end
    end

    // Stage handshakes
    assign rdy_out  = !m_valid_reg || m_tready;
    assign rdy3     = !v3_reg || rdy_out;
    assign rdy2     = !v2_reg || rdy3;
    assign rdy1     = !v1_reg || rdy2;
    assign s_tready = rdy1;
    assign step_en  = v3_reg && rdy_out;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (rdy1)    v1_reg      <= s_tvalid;
            if (rdy2)    v2_reg      <= v1_reg;
            if (rdy3)    v3_reg      <= v2_reg;
            if (rdy_out) m_valid_reg <= v3_reg;
        end
    end

    // Time and health travel alongside the weighted sum
    always_ff @(posedge aclk) begin
        if (rdy1 && s_tvalid) begin
            t1_reg    <= s_tdata[TIME_W-1:0];
            h1_reg[0] <= s_tdata[TIME_W +: HEALTH_W];
            h1_reg[1] <= s_tdata[TIME_W+HEALTH_W +: HEALTH_W];
            h1_reg[2] <= s_tdata[TIME_W+2*HEALTH_W +: HEALTH_W];
        end
        if (rdy2 && v1_reg) begin
            t2_reg <= t1_reg;
            h2_reg <= h1_reg;
        end
        if (rdy3 && v2_reg) begin
            t3_reg <= t2_reg;
            h3_reg <= h2_reg;
        end
    end

    dbm_health u_health (
        .aclk    (aclk),
        .ld_prod (rdy2 && v1_reg),
        .ld_sum  (rdy3 && v2_reg),
        .weight  (weight_reg),
        .health  (h1_reg),
        .overall (overall)
    );

    // Shared back-dated start time, clamped at zero
    assign back_time = (t3_reg >= TIME_W'(offset_reg)) ? t3_reg - TIME_W'(offset_reg) : '0;

    // Overall detector
    dbm_lane #(.TRACK_TIME(1'b0)) u_ov_lane (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .step_en       (step_en),
        .health        (overall),
        .low_threshold (low_thr_reg),
        .eff_debounce  (eff_debounce),
        .sample_time   (t3_reg),
        .back_time     (back_time),
        .stat          (ov_stat),
        .events        (ov_events),
        .active_ms     (ov_ms)
    );

    // Channel detectors, one lane each
    generate
        for (genvar g = 0; g < NUM_CHANNELS; g++) begin : g_ch
            if (g < NUM_FIELDS) begin : g_in
                assign ch_health[g] = h3_reg[g];
            end else begin : g_idle
                assign ch_health[g] = HEALTH_MAX;
            end

            dbm_lane #(.TRACK_TIME(1'b1)) u_lane (
                .aclk          (aclk),
                .aresetn       (aresetn),
                .step_en       (step_en),
                .health        (ch_health[g]),
                .low_threshold (low_thr_reg),
                .eff_debounce  (eff_debounce),
                .sample_time   (t3_reg),
                .back_time     (back_time),
                .stat          (ch_stat[g]),
                .events        (ch_events[g]),
                .active_ms     (ch_ms[g])
            );
        end

        // Reported channels; absent ones read zero
        for (genvar r = 0; r < NUM_FIELDS; r++) begin : g_rep
            if (r < NUM_CHANNELS) begin : g_on
                assign rep_mask[r]   = ch_stat[r].active;
                assign rep_events[r] = ch_events[r];
                assign rep_ms[r]     = ch_ms[r];
            end else begin : g_off
                assign rep_mask[r]   = 1'b0;
                assign rep_events[r] = '0;
                assign rep_ms[r]     = '0;
            end
        end
    endgenerate

    dbm_merge u_merge (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .step_en        (step_en),
        .overall        (overall),
        .recovery_level (recov_lvl_reg),
        .sample_time    (t3_reg),
        .back_time      (back_time),
        .ov_stat        (ov_stat),
        .ov_events      (ov_events | CNT_W'(ov_ms[0] & 1'b0)),
        .ch_mask        (rep_mask),
        .ch_events      (rep_events),
        .ch_ms          (rep_ms),
        .tdata          (m_tdata)
    );

    assign m_tvalid = m_valid_reg;

endmodule

// ===== src/dbm_core_chk.sv =====
`include "debounced_bottleneck_monitor_core_assert.svh"

module dbm_core_chk
    import dbm_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_TDATA_W-1:0] m_tdata
);

    logic [CNT_W-1:0]   ov_events;
    logic [CNT_W-1:0]   events_a;
    logic [STAMP_W-1:0] onset;

    assign ov_events = m_tdata[OFS_OEV +: CNT_W];
    assign events_a  = m_tdata[OFS_EV +: CNT_W];
    assign onset     = m_tdata[OFS_ONSET +: STAMP_W];

    // A stalled result keeps its contents
    `DBM_ASSERT_NXT(a_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "result changed while stalled")

    // Overall health never exceeds full scale
    `DBM_ASSERT_IMP(a_health_max, aclk, aresetn, m_tvalid, m_tdata[OFS_HEALTH +: HEALTH_W] <= HEALTH_MAX, "overall health above full scale")

    // An active overall detector has counted at least one event
    `DBM_ASSERT_IMP(a_active_evt, aclk, aresetn, m_tvalid && m_tdata[OFS_ACTIVE], ov_events != '0, "overall active with no event")

    // The onset stamp is set exactly when an overall event has occurred
    `DBM_ASSERT_IMP(a_onset_evt, aclk, aresetn, m_tvalid, (onset == '1) == (ov_events == '0), "onset stamp disagrees with event count")

    // An active channel 0 has counted at least one event
    `DBM_ASSERT_IMP(a_ch0_evt, aclk, aresetn, m_tvalid && m_tdata[OFS_MASK], events_a != '0, "channel active with no event")

endmodule

bind debounced_bottleneck_monitor_core dbm_core_chk u_dbm_core_chk (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/debounced_bottleneck_monitor_core_tb.sv =====
`timescale 1ns / 1ps

module debounced_bottleneck_monitor_core_tb;
    import dbm_pkg::*;

    localparam int PIPE_LATENCY = 3;
    localparam int HOLD_CYCLES  = 150;
    localparam int STALL_LIMIT  = 2000;
    localparam int PHASE_ITEMS  = 135;
    localparam int NUM_PHASES   = 8;
    localparam int BURST_PAIRS  = 20;
    localparam int MAX_PRINTS   = 100;

    localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = 3'd7;

    localparam logic [CFG_DATA_W-1:0] DEF_WEIGHT_A = 16'd307;
    localparam logic [CFG_DATA_W-1:0] DEF_WEIGHT_B = 16'd512;
    localparam logic [CFG_DATA_W-1:0] DEF_WEIGHT_C = 16'd205;
    localparam logic [CFG_DATA_W-1:0] DEF_LOW_THR  = 16'd12800;
    localparam logic [CFG_DATA_W-1:0] DEF_RECOVERY = 16'd17920;
    localparam logic [CFG_DATA_W-1:0] DEF_DEBOUNCE = 16'd5;
    localparam logic [CFG_DATA_W-1:0] DEF_INTERVAL = 16'd1000;

    localparam health_t H_TOP = '1;

    // s_tdata layout, lowest field last
    typedef struct packed {
        logic [2:0] pad;
        health_t    hc;
        health_t    hb;
        health_t    ha;
        time_t      stamp;
    } sample_t;

    // m_tdata layout, lowest field last
    typedef struct packed {
        logic [2:0]         pad;
        logic [STAMP_W-1:0] recovery;
        logic [STAMP_W-1:0] onset;
        logic [TIME_W-1:0]  ms_c;
        logic [TIME_W-1:0]  ms_b;
        logic [TIME_W-1:0]  ms_a;
        logic [CNT_W-1:0]   ev_c;
        logic [CNT_W-1:0]   ev_b;
        logic [CNT_W-1:0]   ev_a;
        logic [CNT_W-1:0]   oev;
        logic [2:0]         mask;
        logic               active;
        health_t            health;
    } result_t;

    typedef struct packed {
        time_t   stamp;
        health_t ha;
        health_t hb;
        health_t hc;
        logic    typed;
        health_t health;
    } dir_row_t;

    typedef enum int {H_LOW, H_HIGH, H_EDGE, H_NOISE} health_mode_t;

    // Directed rows at reset settings (weights 307/512/205, threshold 12800,
    // debounce 5, interval 1000). Overall health typed in where obvious.
    localparam dir_row_t DIRECTED [0:21] = '{
        // full health and all zero
        '{32'd0,    HEALTH_MAX, HEALTH_MAX, HEALTH_MAX, 1'b1, HEALTH_MAX},
        '{32'd0,    15'd0, 15'd0, 15'd0, 1'b1, 15'd0},
        // low run reaches debounce; start back-dated below zero, clamps
        '{32'd500,  15'd0, 15'd0, 15'd0, 1'b0, 15'd0},
        '{32'd1000, 15'd0, 15'd0, 15'd0, 1'b0, 15'd0},
        '{32'd1500, 15'd0, 15'd0, 15'd0, 1'b0, 15'd0},
        '{32'd2000, 15'd0, 15'd0, 15'd0, 1'b0, 15'd0},
        // out-of-range health saturates overall, recovery, runs close
        '{32'd2500, H_TOP, H_TOP, H_TOP, 1'b1, HEALTH_MAX},
        // threshold boundary: equal is not low, one below is
        '{32'd3000, 15'd12800, 15'd12800, 15'd12800, 1'b1, 15'd12800},
        '{32'd3500, 15'd12799, 15'd12799, 15'd12799, 1'b1, 15'd12799},
        // channel a run, then closed at an earlier time
        '{32'd100000, 15'd0, HEALTH_MAX, HEALTH_MAX, 1'b0, 15'd0},
        '{32'd101000, 15'd0, HEALTH_MAX, HEALTH_MAX, 1'b0, 15'd0},
        '{32'd102000, 15'd0, HEALTH_MAX, HEALTH_MAX, 1'b0, 15'd0},
        '{32'd103000, 15'd0, HEALTH_MAX, HEALTH_MAX, 1'b0, 15'd0},
        '{32'd104000, 15'd0, HEALTH_MAX, HEALTH_MAX, 1'b0, 15'd0},
        '{32'd50,   HEALTH_MAX, HEALTH_MAX, HEALTH_MAX, 1'b0, 15'd0},
        // channel c run over the whole time range, total saturates
        '{32'd0,    HEALTH_MAX, HEALTH_MAX, 15'd0, 1'b0, 15'd0},
        '{32'd0,    HEALTH_MAX, HEALTH_MAX, 15'd0, 1'b0, 15'd0},
        '{32'd0,    HEALTH_MAX, HEALTH_MAX, 15'd0, 1'b0, 15'd0},
        '{32'd0,    HEALTH_MAX, HEALTH_MAX, 15'd0, 1'b0, 15'd0},
        '{32'd0,    HEALTH_MAX, HEALTH_MAX, 15'd0, 1'b0, 15'd0},
        '{32'hFFFF_FFFF, HEALTH_MAX, HEALTH_MAX, HEALTH_MAX, 1'b0, 15'd0},
        '{32'hFFFF_FFFF, H_TOP, H_TOP, 15'd0, 1'b0, 15'd0}
    };

    logic                  aclk;
    logic                  aresetn;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [CFG_DATA_W-1:0] cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;

    // Model configuration
    logic [WEIGHT_W-1:0] cfg_weight_a, cfg_weight_b, cfg_weight_c;
    health_t             cfg_low_thr, cfg_recovery;
    logic [RUN_W-1:0]    cfg_debounce;
    logic [INTV_W-1:0]   cfg_interval;

    // Model state
    logic [RUN_W-1:0]  overall_run;
    bit                overall_was_active;
    logic [CNT_W-1:0]  overall_events;
    longint            onset_stamp;
    longint            recovery_stamp;
    logic [RUN_W-1:0]  chan_run [3];
    bit                chan_was_active [3];
    logic [CNT_W-1:0]  chan_events [3];
    longint            chan_start [3];
    logic [TIME_W-1:0] chan_total [3];

    result_t pending_results [$];
    int      mismatch_count;
    int      result_count;
    int      stall_cycles;
    bit      send_idle;
    bit      recv_idle;
    bit      recv_free;
    bit      hold_req;

    debounced_bottleneck_monitor_core u_top (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ---------------------------------------------------------------
    // Monitor model
    // ---------------------------------------------------------------
    function automatic logic [RUN_W-1:0] next_run(logic [RUN_W-1:0] run, bit is_low);
        if (!is_low)
            return '0;
        return (run == RUN_MAX) ? RUN_MAX : run + 1'b1;
    endfunction

    function automatic logic [CNT_W-1:0] bump_count(logic [CNT_W-1:0] cnt);
        return (cnt == CNT_MAX) ? CNT_MAX : cnt + 1'b1;
    endfunction

    // start of a run: debounce-1 intervals before this sample, not below 0
    function automatic longint run_start_of(time_t stamp, logic [RUN_W-1:0] deb);
        longint b;
        b = $signed({32'b0, stamp})
            - ($signed({56'b0, deb}) - 64'sd1) * $signed({48'b0, cfg_interval});
        return (b < 0) ? 64'sd0 : b;
    endfunction

    function automatic void reset_monitor_model();
        cfg_weight_a = DEF_WEIGHT_A[WEIGHT_W-1:0];
        cfg_weight_b = DEF_WEIGHT_B[WEIGHT_W-1:0];
        cfg_weight_c = DEF_WEIGHT_C[WEIGHT_W-1:0];
        cfg_low_thr  = DEF_LOW_THR[HEALTH_W-1:0];
        cfg_recovery = DEF_RECOVERY[HEALTH_W-1:0];
        cfg_debounce = DEF_DEBOUNCE[RUN_W-1:0];
        cfg_interval = DEF_INTERVAL[INTV_W-1:0];
        overall_run        = '0;
        overall_was_active = 1'b0;
        overall_events     = '0;
        onset_stamp        = -1;
        recovery_stamp     = -1;
        for (int i = 0; i < 3; i++) begin
            chan_run[i]        = '0;
            chan_was_active[i] = 1'b0;
            chan_events[i]     = '0;
            chan_start[i]      = -1;
            chan_total[i]      = '0;
        end
    endfunction

    function automatic void apply_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        unique case (idx)
            REG_WEIGHT_A:   cfg_weight_a = val[WEIGHT_W-1:0];
            REG_WEIGHT_B:   cfg_weight_b = val[WEIGHT_W-1:0];
            REG_WEIGHT_C:   cfg_weight_c = val[WEIGHT_W-1:0];
            REG_LOW_THRESH: cfg_low_thr  = val[HEALTH_W-1:0];
            REG_RECOVERY:   cfg_recovery = val[HEALTH_W-1:0];
            REG_DEBOUNCE:   cfg_debounce = val[RUN_W-1:0];
            REG_INTERVAL:   cfg_interval = val[INTV_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic result_t next_monitor_result(sample_t s);
        result_t          r;
        logic [63:0]      acc;
        health_t          overall;
        health_t          hv [3];
        logic [RUN_W-1:0] deb;
        bit               is_low;
        bit               act;
        longint           dur;
        longint           tot;
        r = '0;
        hv[0] = s.ha;
        hv[1] = s.hb;
        hv[2] = s.hc;
        deb = (cfg_debounce == 0) ? 8'd1 : cfg_debounce;

        // weighted health, rounded half up, saturated
        acc = 64'(cfg_weight_a) * 64'(s.ha) + 64'(cfg_weight_b) * 64'(s.hb)
            + 64'(cfg_weight_c) * 64'(s.hc) + 64'(ROUND_HALF);
        acc = acc >> FRAC_BITS;
        overall = (acc > 64'(HEALTH_MAX)) ? HEALTH_MAX : acc[HEALTH_W-1:0];

        // overall detector
        is_low = overall < cfg_low_thr;
        overall_run = next_run(overall_run, is_low);
        act = overall_run >= deb;
        if (act && !overall_was_active) begin
            overall_events = bump_count(overall_events);
            if (onset_stamp < 0)
                onset_stamp = run_start_of(s.stamp, deb);
        end
        if (!is_low && overall_was_active && recovery_stamp < 0 && overall > cfg_recovery)
            recovery_stamp = $signed({32'b0, s.stamp});
        overall_was_active = act;
        r.health = overall;
        r.active = act;

        // channel detectors and closed active time
        for (int i = 0; i < 3; i++) begin
            is_low = hv[i] < cfg_low_thr;
            chan_run[i] = next_run(chan_run[i], is_low);
            act = chan_run[i] >= deb;
            if (act && !chan_was_active[i]) begin
                chan_events[i] = bump_count(chan_events[i]);
                chan_start[i] = run_start_of(s.stamp, deb);
            end
            if (!act && chan_was_active[i] && chan_start[i] >= 0) begin
                dur = $signed({32'b0, s.stamp}) - chan_start[i];
                if (dur < 0)
                    dur = 0;
                tot = $signed({32'b0, chan_total[i]}) + dur;
                chan_total[i] = (tot > 64'sh0_FFFF_FFFF) ? '1 : tot[TIME_W-1:0];
                chan_start[i] = -1;
            end
            chan_was_active[i] = act;
            r.mask[i] = act;
        end

        r.oev      = overall_events;
        r.ev_a     = chan_events[0];
        r.ev_b     = chan_events[1];
        r.ev_c     = chan_events[2];
        r.ms_a     = chan_total[0];
        r.ms_b     = chan_total[1];
        r.ms_c     = chan_total[2];
        r.onset    = onset_stamp[STAMP_W-1:0];
        r.recovery = recovery_stamp[STAMP_W-1:0];
        return r;
    endfunction

    // ---------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------
    task automatic report_mismatch(input string what);
        if (mismatch_count < MAX_PRINTS)
            $display("[%0t] result %0d: %s", $realtime, result_count, what);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [STAMP_W-1:0] got,
                               input logic [STAMP_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
    endtask

    task automatic check_result(input result_t got);
        result_t want;
        if (pending_results.size() == 0) begin
            report_mismatch("result with no item pending");
        end else begin
            want = pending_results.pop_front();
            check_field("overall_health", 33'(got.health), 33'(want.health));
            check_field("overall_active", 33'(got.active), 33'(want.active));
            check_field("channel_active_mask", 33'(got.mask), 33'(want.mask));
            check_field("overall_events", 33'(got.oev), 33'(want.oev));
            check_field("events_a", 33'(got.ev_a), 33'(want.ev_a));
            check_field("events_b", 33'(got.ev_b), 33'(want.ev_b));
            check_field("events_c", 33'(got.ev_c), 33'(want.ev_c));
            check_field("active_ms_a", 33'(got.ms_a), 33'(want.ms_a));
            check_field("active_ms_b", 33'(got.ms_b), 33'(want.ms_b));
            check_field("active_ms_c", 33'(got.ms_c), 33'(want.ms_c));
            check_field("first_onset_ms", got.onset, want.onset);
            check_field("first_recovery_ms", got.recovery, want.recovery);
        end
        result_count++;
    endtask

    // ---------------------------------------------------------------
    // Sender side
    // ---------------------------------------------------------------
    task automatic send_item(input sample_t s, input logic typed, input health_t typed_health);
        int      gap;
        result_t want;
        gap = send_idle ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge aclk); while (s_tready !== 1'b1);
        want = next_monitor_result(s);
        if (typed)
            want.health = typed_health;
        pending_results.push_back(want);
    endtask

    // wait until every result is back and the pipe has gone quiet
    task automatic wait_drain();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (PIPE_LATENCY + 1) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
        apply_reg(idx, val);
    endtask

    task automatic apply_config(input logic [CFG_DATA_W-1:0] w_a, w_b, w_c,
                                input logic [CFG_DATA_W-1:0] thr, rec, deb, intv);
        wait_drain();
        write_reg(REG_WEIGHT_A, w_a);
        write_reg(REG_WEIGHT_B, w_b);
        write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        write_reg(REG_WEIGHT_C, w_c);
        write_reg(REG_LOW_THRESH, thr);
        write_reg(REG_RECOVERY, rec);
        write_reg(REG_DEBOUNCE, deb);
        write_reg(REG_INTERVAL, intv);
        // debounce/interval are registered before they reach the back-dating offset
        repeat (2) @(posedge aclk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] draw_weight();
        unique case ($urandom_range(0, 5))
            0: return 16'd0;
            1: return 16'd1024;
            2: return 16'd2047;
            3: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(0, 1024));
        endcase
    endfunction

    function automatic logic [CFG_DATA_W-1:0] draw_level();
        unique case ($urandom_range(0, 7))
            0: return 16'd0;
            1: return 16'd25600;
            2: return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(6400, 19200));
        endcase
    endfunction

    function automatic health_mode_t draw_mode();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0)
            return H_EDGE;
        if (pick == 1)
            return H_NOISE;
        return (pick < 6) ? H_LOW : H_HIGH;
    endfunction

    function automatic health_t draw_health(health_mode_t mode);
        int thr;
        thr = int'(cfg_low_thr);
        unique case (mode)
            H_LOW:
                return (thr == 0) ? health_t'(0) : health_t'($urandom_range(0, thr - 1));
            H_HIGH:
                return health_t'($urandom_range(thr, (thr > 25600) ? 32767 : 25600));
            H_EDGE:
                return (thr != 0 && $urandom_range(0, 1) == 1) ? health_t'(thr - 1)
                                                               : health_t'(thr);
            default:
                return health_t'($urandom_range(0, 32767));
        endcase
    endfunction

    // Segments of steady per-channel behavior, mostly around the debounce
    // length, some short broken runs and a few long ones.
    task automatic run_random(input int phase_no, input int n_items);
        health_mode_t     modes [3];
        int               seg_left;
        int               pick;
        logic [RUN_W-1:0] deb;
        sample_t          s;
        seg_left = 0;
        s = '0;
        s.stamp = $urandom;
        for (int k = 0; k < n_items; k++) begin
            if (seg_left == 0) begin
                deb = (cfg_debounce == 0) ? 8'd1 : cfg_debounce;
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    seg_left = $urandom_range(1, int'(deb) + 3);
                else if (pick < 9)
                    seg_left = $urandom_range(1, 3);
                else
                    seg_left = $urandom_range(1, 300);
                for (int c = 0; c < 3; c++)
                    modes[c] = draw_mode();
                send_idle = ($urandom_range(0, 3) != 0);
            end
            seg_left--;

            // fill the pipe against a stalled receiver, later drain it
            if (phase_no == 3 && k == 40) begin
                hold_req = 1'b1;
                send_idle = 1'b0;
            end
            if (phase_no == 4 && k == 90)
                wait_drain();

            pick = $urandom_range(0, 15);
            if (pick == 0)
                s.stamp = $urandom;
            else if (pick == 1)
                s.stamp = s.stamp - time_t'($urandom_range(0, 5000));
            else
                s.stamp = s.stamp + time_t'(cfg_interval);
            s.ha = draw_health(modes[0]);
            s.hb = draw_health(modes[1]);
            s.hc = draw_health(modes[2]);
            send_item(s, 1'b0, '0);
        end
    endtask

    // ---------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------
    initial begin : stimulus
        sample_t s;
        aresetn     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= '0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        send_idle      = 1'b1;
        recv_idle      = 1'b1;
        recv_free      = 1'b0;
        hold_req       = 1'b0;
        mismatch_count = 0;
        result_count   = 0;
        reset_monitor_model();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows at reset settings
        for (int i = 0; i < $size(DIRECTED); i++) begin
            s = '0;
            s.stamp = DIRECTED[i].stamp;
            s.ha    = DIRECTED[i].ha;
            s.hb    = DIRECTED[i].hb;
            s.hc    = DIRECTED[i].hc;
            send_item(s, DIRECTED[i].typed, DIRECTED[i].health);
        end

        // random phases over several settings
        for (int p = 0; p < NUM_PHASES; p++) begin
            if (p == 1)
                // zero weights, overall always low, zero debounce, interval of one
                apply_config(16'd0, 16'd0, 16'd0, 16'd25600, 16'd0, 16'd0, 16'd1);
            else if (p == 2)
                // largest values; runs saturate, recovery never reached
                apply_config(16'd2047, 16'd2047, 16'd2047, 16'h7FFF, 16'h7FFF,
                             16'd255, 16'hFFFF);
            else if (p > 2)
                apply_config(draw_weight(), draw_weight(), draw_weight(),
                             draw_level(), draw_level(),
                             ($urandom_range(0, 3) == 0) ? CFG_DATA_W'($urandom)
                                                         : CFG_DATA_W'($urandom_range(0, 12)),
                             CFG_DATA_W'($urandom_range(0, 65535)));
            run_random(p, PHASE_ITEMS);
        end

        // back-to-back activations with both sides running freely
        apply_config(DEF_WEIGHT_A, DEF_WEIGHT_B, DEF_WEIGHT_C, DEF_LOW_THR,
                     DEF_RECOVERY, 16'd1, DEF_INTERVAL);
        send_idle = 1'b0;
        recv_free = 1'b1;
        s = '0;
        for (int k = 0; k < 2 * BURST_PAIRS; k++) begin
            s.stamp = s.stamp + time_t'(cfg_interval);
            s.ha = (k % 2 == 0) ? health_t'(0) : HEALTH_MAX;
            s.hb = s.ha;
            s.hc = s.ha;
            send_item(s, 1'b0, '0);
        end

        wait_drain();
        if (mismatch_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // ---------------------------------------------------------------
    // Receiver side
    // ---------------------------------------------------------------
    initial begin : result_sink
        int gap;
        m_tready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req) begin
                gap = HOLD_CYCLES;
                hold_req = 1'b0;
            end else if (!recv_free && recv_idle) begin
                gap = $urandom_range(0, 10);
            end else begin
                gap = 0;
            end
            if ($urandom_range(0, 19) == 0)
                recv_idle = !recv_idle;
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (m_tvalid !== 1'b1);
            check_result(result_t'(m_tdata));
        end
    end

    // watchdog: too long without any item moving on either side
    always @(posedge aclk) begin
        if (aresetn !== 1'b1 || (s_tvalid && s_tready === 1'b1)
                || (m_tvalid === 1'b1 && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
